>>> hw/rtl/i2cm_pkg.sv
// i2cm_pkg: shared types and codes of the i2c master bit engine
// phase codes, command codes, register indexes, state / config / result structs
// no dependencies
package i2cm_pkg;

    localparam int PHASE_W   = 4;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ST_A    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ST_B    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SP_A    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SP_B    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_HI   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_LO   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WA_HI   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WA_POLL = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_HI   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_LO   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RD_ACK  = 4'd11;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAIT_ACK = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd2;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [15:0] SAMPLE_RESET      = 16'd4;
    localparam logic [9:0]  ACK_TIMEOUT_RESET = 10'd250;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [15:0] sample_ticks;
        logic [9:0]  ack_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CMD_W-1:0]   active_command;
        logic [3:0]         bit_index;
        logic [7:0]         shift_byte;
        logic [15:0]        delay_count;
        logic [9:0]         wait_count;
        logic               ack_choice;
        logic               scl;
        logic               sda;
        logic               sda_drive;
        logic [7:0]         read_data;
        logic               ack_received;
        logic               timed_out;
    } state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_received;
        logic       timed_out;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_IDLE,
        active_command: CMD_NONE,
        bit_index:      4'd0,
        shift_byte:     8'd0,
        delay_count:    16'd0,
        wait_count:     10'd0,
        ack_choice:     1'b0,
        scl:            1'b1,
        sda:            1'b1,
        sda_drive:      1'b0,
        read_data:      8'd0,
        ack_received:   1'b0,
        timed_out:      1'b0
    };

endpackage

>>> hw/rtl/i2cm_cfg_regs.sv
// i2cm_cfg_regs: timing configuration registers of the i2c master bit engine
// depends on i2cm_pkg (cfg_t, register indexes, reset values)
module i2cm_cfg_regs
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_HALF_PERIOD: cfg_next.half_period_ticks = cfg_data;
                REG_SAMPLE:      cfg_next.sample_ticks      = cfg_data;
                REG_ACK_TIMEOUT: cfg_next.ack_timeout_ticks = cfg_data[9:0];
                default:         cfg_next = cfg_reg;  // unmapped index dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RESET;
            cfg_reg.sample_ticks      <= SAMPLE_RESET;
            cfg_reg.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/i2cm_step.sv
// i2cm_step: one tick of the bus sequencer, next state and line / status result
// depends on i2cm_pkg (state_t, cfg_t, result_t, phase and command codes)
module i2cm_step
    import i2cm_pkg::*;
(
    input  state_t           cur,
    input  cfg_t             cfg,
    input  logic [CMD_W-1:0] cmd,
    input  logic [7:0]       write_byte,
    input  logic             send_ack,
    input  logic             sda_in,
    output state_t           nxt,
    output result_t          res
);

    function automatic state_t enter_seg(state_t s, logic [PHASE_W-1:0] p,
                                         logic scl, logic sda, logic drv);
        state_t r;
        r             = s;
        r.phase       = p;
        r.delay_count = 16'd0;
        r.scl         = scl;
        r.sda         = sda;
        r.sda_drive   = drv;
        return r;
    endfunction

    // ack poll: low sample ends with ack, timeout starts a stop
    function automatic state_t poll_ack(state_t s, logic sda, logic [9:0] limit);
        state_t r;
        r = s;
        if (!sda) begin
            r              = enter_seg(s, PH_IDLE, 1'b0, 1'b1, 1'b0);
            r.ack_received = 1'b1;
            r.timed_out    = 1'b0;
        end else if (s.wait_count >= limit) begin
            r = enter_seg(s, PH_SP_A, 1'b1, 1'b0, 1'b1);
        end else begin
            r.wait_count = s.wait_count + 10'd1;
            r.phase      = PH_WA_POLL;
        end
        return r;
    endfunction

    logic [15:0] delay_inc;
    logic [15:0] seg_raw;
    logic [15:0] seg_len;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_left;
    logic        done;

    assign delay_inc  = cur.delay_count + 16'd1;
    assign seg_raw    = (cur.phase == PH_WA_HI || cur.phase == PH_RD_HI ||
                         cur.phase == PH_RD_LO) ? cfg.sample_ticks : cfg.half_period_ticks;
    assign seg_len    = (seg_raw == 16'd0) ? 16'd1 : seg_raw;
    assign bit_inc    = cur.bit_index + 4'd1;
    assign shift_left = {cur.shift_byte[6:0], 1'b0};

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        if (cur.phase == PH_WA_POLL) begin
            nxt  = poll_ack(cur, sda_in, cfg.ack_timeout_ticks);
            done = !sda_in;
        end else if (cur.phase != PH_IDLE) begin
            nxt.delay_count = delay_inc;
            if (delay_inc >= seg_len) begin
                case (cur.phase)
                    PH_ST_A: nxt = enter_seg(cur, PH_ST_B, 1'b1, 1'b0, 1'b1);
                    PH_ST_B: begin
                        nxt  = enter_seg(cur, PH_IDLE, 1'b0, 1'b0, 1'b1);
                        done = 1'b1;
                    end
                    PH_SP_A: nxt = enter_seg(cur, PH_SP_B, 1'b1, 1'b1, 1'b1);
                    PH_SP_B: begin
                        nxt  = enter_seg(cur, PH_IDLE, 1'b1, 1'b1, 1'b1);
                        done = 1'b1;
                        // stop issued by an ack wait that gave up
                        if (cur.active_command == CMD_WAIT_ACK) begin
                            nxt.ack_received = 1'b0;
                            nxt.timed_out    = 1'b1;
                        end
                    end
                    PH_WR_HI: nxt = enter_seg(cur, PH_WR_LO, 1'b0, cur.sda, 1'b1);
                    PH_WR_LO: begin
                        if (bit_inc < 4'd8) begin
                            nxt = enter_seg(cur, PH_WR_HI, 1'b1, shift_left[7], 1'b1);
                        end else begin
                            nxt  = enter_seg(cur, PH_IDLE, 1'b0, cur.sda, 1'b1);
                            done = 1'b1;
                        end
                        nxt.bit_index  = bit_inc;
                        nxt.shift_byte = shift_left;
                    end
                    PH_WA_HI: begin
                        nxt  = poll_ack(cur, sda_in, cfg.ack_timeout_ticks);
                        done = !sda_in;
                    end
                    PH_RD_HI: begin
                        nxt            = enter_seg(cur, PH_RD_LO, 1'b0, 1'b1, 1'b0);
                        nxt.shift_byte = {cur.shift_byte[6:0], sda_in};
                    end
                    PH_RD_LO: begin
                        if (bit_inc < 4'd8) begin
                            nxt = enter_seg(cur, PH_RD_HI, 1'b1, 1'b1, 1'b0);
                        end else begin
                            nxt = enter_seg(cur, PH_RD_ACK, 1'b1, !cur.ack_choice, 1'b1);
                        end
                        nxt.bit_index = bit_inc;
                    end
                    PH_RD_ACK: begin
                        nxt           = enter_seg(cur, PH_IDLE, 1'b0, cur.sda, 1'b1);
                        nxt.read_data = cur.shift_byte;
                        done          = 1'b1;
                    end
                    default: nxt.phase = PH_IDLE;
                endcase
            end
        end else if (cmd inside {[CMD_START:CMD_WAIT_ACK]}) begin
            nxt.active_command = cmd;
            nxt.bit_index      = 4'd0;
            case (cmd)
                CMD_START: nxt = enter_seg(nxt, PH_ST_A, 1'b1, 1'b1, 1'b1);
                CMD_STOP:  nxt = enter_seg(nxt, PH_SP_A, 1'b1, 1'b0, 1'b1);
                CMD_WRITE: begin
                    nxt.shift_byte = write_byte;
                    nxt            = enter_seg(nxt, PH_WR_HI, 1'b1, write_byte[7], 1'b1);
                end
                CMD_READ: begin
                    nxt.shift_byte = 8'd0;
                    nxt.ack_choice = send_ack;
                    nxt            = enter_seg(nxt, PH_RD_HI, 1'b1, 1'b1, 1'b0);
                end
                default: begin
                    nxt.wait_count = 10'd0;
                    nxt            = enter_seg(nxt, PH_WA_HI, 1'b1, 1'b1, 1'b0);
                end
            endcase
        end
    end

    always_comb begin
        res.scl_level    = nxt.scl;
        res.sda_level    = nxt.sda_drive ? nxt.sda : 1'b1;  // released line reads high
        res.sda_drive    = nxt.sda_drive;
        res.busy_res     = (nxt.phase != PH_IDLE);
        res.done_res     = done;
        res.read_data    = nxt.read_data;
        res.ack_received = nxt.ack_received;
        res.timed_out    = nxt.timed_out;
    end

endmodule

>>> hw/rtl/i2c_master_bit_engine.sv
// i2c_master_bit_engine: top level, input register, sequencer state, result register
// depends on i2cm_pkg, i2cm_cfg_regs, i2cm_step
//
// I2C master bit engine. Each request on the s_ channel is one tick of the bus timing
// base, carrying an optional command (start, stop, write byte, read byte, wait for ACK)
// and the sampled SDA pin; each tick returns exactly one result on the m_ channel with the
// SCL / SDA levels, SDA drive enable, busy, done, last read byte and last ACK status. One
// request is taken every clock unless a stalled result holds the input register; the request
// lands in the input register, and the combinational sequencer step moves it into the result
// register when that register is free or being read. The clock rate is set by that step, mainly
// the 16-bit segment counter add and compare. Commands given while busy are ignored. Timing
// registers are written through the cfg_ port (index 0 half period, 1 sample ticks, 2 ACK
// timeout), only by the user while no ticks are in flight; the block does not enforce it.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tick requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_cmd,
    input  logic [7:0]           s_write_byte,
    input  logic                 s_send_ack,
    input  logic                 s_sda_in,
    // tick results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_scl_level,
    output logic                 m_sda_level,
    output logic                 m_sda_drive,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic [7:0]           m_read_data,
    output logic                 m_ack_received,
    output logic                 m_timed_out,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_comb;
    result_t res_reg;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [7:0]       wbyte_reg;
    logic             sack_reg;
    logic             sda_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             s_accept;
    logic             fire;

    assign cfg_ready = 1'b1;

    i2cm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // step fires when the held tick can move into the result register
    assign fire     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || fire;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_cmd;
            wbyte_reg <= s_write_byte;
            sack_reg  <= s_send_ack;
            sda_reg   <= s_sda_in;
        end
        if (fire) begin
            res_reg <= res_comb;
        end
    end

    i2cm_step u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .cmd        (cmd_reg),
        .write_byte (wbyte_reg),
        .send_ack   (sack_reg),
        .sda_in     (sda_reg),
        .nxt        (state_next),
        .res        (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_scl_level    = res_reg.scl_level;
    assign m_sda_level    = res_reg.sda_level;
    assign m_sda_drive    = res_reg.sda_drive;
    assign m_busy_res     = res_reg.busy_res;
    assign m_done_res     = res_reg.done_res;
    assign m_read_data    = res_reg.read_data;
    assign m_ack_received = res_reg.ack_received;
    assign m_timed_out    = res_reg.timed_out;

endmodule

>>> hw/rtl/i2cm_checker.sv
// i2cm_checker: port-level checks of the i2c master bit engine, bound to the top level
// depends only on the result port names of i2c_master_bit_engine
module i2cm_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_scl_level,
    input logic                 m_sda_level,
    input logic                 m_sda_drive,
    input logic                 m_busy_res,
    input logic                 m_done_res,
    input logic [7:0]           m_read_data,
    input logic                 m_ack_received,
    input logic                 m_timed_out
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_scl_level, m_sda_level, m_sda_drive, m_busy_res, m_done_res,
                     m_read_data, m_ack_received, m_timed_out}))
        else $error("result changed while stalled");

    // a completing command leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done reported while still busy");

    // released sda reads as pulled up
    a_released_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sda_drive |-> m_sda_level)
        else $error("released sda not high");

    // timeout and ack are exclusive outcomes of one ack wait
    a_ack_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timed_out |-> !m_ack_received)
        else $error("timeout reported together with ack");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
